// ===== rtl/psd_pkg.sv =====
`timescale 1ns / 1ps

package psd_pkg;

	// Coordinate and result formats.
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int T_BITS     = 16;
	localparam int DIST_W     = 25;

	// Derived widths.
	localparam int DW     = COORD_BITS + 1;        // coordinate difference
	localparam int LEN_W  = 2 * DW;                // squared length
	localparam int PROJ_W = 2 * DW + 1;            // dot product
	localparam int TW     = T_BITS + 1;            // clamped t, Q1.T_BITS
	localparam int ERR_W  = DW + TW + 1;           // error vector, Q.T_BITS
	localparam int HALF_W = (ERR_W + 1) / 2;       // low half for squaring
	localparam int HI_W   = ERR_W - HALF_W;        // high half for squaring
	localparam int SQE_W  = 2 * ERR_W;             // one squared axis
	localparam int RT_W   = ERR_W + 1;             // square root
	localparam int SQ_W   = 2 * RT_W;              // radicand
	localparam int RW     = RT_W + 3;              // root remainder

	// Geometry that travels with an item.
	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [DW-1:0] rx;
		logic signed [DW-1:0] ry;
	} geo_t;

	// Geometry plus the outcome of the clamp test.
	typedef struct packed {
		geo_t g;
		logic degen;
		logic t_zero;
		logic t_one;
	} side_t;

endpackage

// ===== rtl/point_segment_distance_unit.sv =====
`timescale 1ns / 1ps

// Point to segment distance unit.
// The input channel (in_valid, in_stall) takes one word per cycle unless stalled: a query
// point and the two endpoints of a segment, all signed integers. The output
// channel (out_valid, out_stall) returns one word for each input word, in
// order: the distance from the point to the segment in unsigned fixed point
// with eight fraction bits, truncated, and a flag that is set when the two
// endpoints coincide (the distance is then taken to the start point).
// The word passes 64 register stages on its way to the output. The stages are
// four of differences and dot products, sixteen of a one bit per stage
// divider for t, seven that clamp t and square the error vector,
// thirty six of a one bit per stage square root, and the output
// register. Throughput is one word per cycle unless the receiver stalls;
// no loop feeds back.
// Reset clears every valid bit, so the pipeline comes up empty.
// When the receiver stalls a valid output word, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated, and the
// output register keeps the waiting word stable.
module point_segment_distance_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [psd_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [psd_pkg::COORD_BITS-1:0] point_y,
	input  logic signed [psd_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [psd_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [psd_pkg::COORD_BITS-1:0] end_x,
	input  logic signed [psd_pkg::COORD_BITS-1:0] end_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [psd_pkg::DIST_W-1:0]            distance,
	output logic                                  degenerate
);

	logic                          en;
	logic                          f_vld, d_vld, e_vld, r_vld;
	psd_pkg::side_t                f_side, d_side;
	logic [psd_pkg::LEN_W-1:0]     f_rem, f_len2;
	logic [psd_pkg::T_BITS-1:0]    d_quo;
	logic                          e_degen, r_degen;
	logic [psd_pkg::SQ_W-1:0]      e_sum;
	logic [psd_pkg::RT_W-1:0]      r_root;
	logic                          vld_q;
	logic [psd_pkg::DIST_W-1:0]    dist_q;
	logic                          degen_q;

	// The pipeline advances unless a finished word is being stalled.
	assign en       = !(vld_q && out_stall);
	assign in_stall = !en;

	psd_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(in_valid),
		.px(point_x), .py(point_y), .sx(start_x), .sy(start_y),
		.ex(end_x), .ey(end_y),
		.out_vld(f_vld), .side(f_side), .rem(f_rem), .len2(f_len2)
	);

	psd_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(f_vld),
		.in_side(f_side), .in_rem(f_rem), .in_len2(f_len2),
		.out_vld(d_vld), .out_side(d_side), .quo(d_quo)
	);

	psd_err u_err (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(d_vld),
		.in_side(d_side), .quo(d_quo),
		.out_vld(e_vld), .out_degen(e_degen), .sum(e_sum)
	);

	psd_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(e_vld),
		.in_degen(e_degen), .rad(e_sum),
		.out_vld(r_vld), .out_degen(r_degen), .root(r_root)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= r_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q  <= psd_pkg::DIST_W'(r_root >> (psd_pkg::T_BITS - psd_pkg::FRAC_BITS));
			degen_q <= r_degen;
		end
	end

	assign out_valid  = vld_q;
	assign distance   = dist_q;
	assign degenerate = degen_q;

	// A word leaves the output only when it was taken.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("output word dropped while stalled");

endmodule

// ===== rtl/psd_front.sv =====
`timescale 1ns / 1ps

module psd_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_vld,
	input  logic signed [psd_pkg::COORD_BITS-1:0] px,
	input  logic signed [psd_pkg::COORD_BITS-1:0] py,
	input  logic signed [psd_pkg::COORD_BITS-1:0] sx,
	input  logic signed [psd_pkg::COORD_BITS-1:0] sy,
	input  logic signed [psd_pkg::COORD_BITS-1:0] ex,
	input  logic signed [psd_pkg::COORD_BITS-1:0] ey,
	output logic                                  out_vld,
	output psd_pkg::side_t                        side,
	output logic [psd_pkg::LEN_W-1:0]             rem,
	output logic [psd_pkg::LEN_W-1:0]             len2
);

	localparam int CW = psd_pkg::COORD_BITS;
	localparam int DW = psd_pkg::DW;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	psd_pkg::geo_t        geo_s1, geo_s2, geo_s3;
	logic signed [2*DW-1:0] dxx_s2, dyy_s2, pxx_s2, pyy_s2;
	logic [psd_pkg::LEN_W-1:0]  len2_s3, len2_s4;
	logic signed [psd_pkg::PROJ_W-1:0] proj_s3;
	psd_pkg::side_t       side_s4;
	logic [psd_pkg::LEN_W-1:0]  rem_s4;
	logic                 tz;

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Sign test for the projection.
	assign tz = proj_s3[psd_pkg::PROJ_W-1] || (proj_s3 == '0);

	// Differences, products, sums, then the clamp decision.
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1.dx <= {ex[CW-1], ex} - {sx[CW-1], sx};
			geo_s1.dy <= {ey[CW-1], ey} - {sy[CW-1], sy};
			geo_s1.rx <= {px[CW-1], px} - {sx[CW-1], sx};
			geo_s1.ry <= {py[CW-1], py} - {sy[CW-1], sy};

			geo_s2 <= geo_s1;
			dxx_s2 <= geo_s1.dx * geo_s1.dx;
			dyy_s2 <= geo_s1.dy * geo_s1.dy;
			pxx_s2 <= geo_s1.dx * geo_s1.rx;
			pyy_s2 <= geo_s1.dy * geo_s1.ry;

			geo_s3  <= geo_s2;
			len2_s3 <= psd_pkg::LEN_W'(dxx_s2 + dyy_s2);
			proj_s3 <= {pxx_s2[2*DW-1], pxx_s2} + {pyy_s2[2*DW-1], pyy_s2};

			side_s4.g      <= geo_s3;
			side_s4.degen  <= (len2_s3 == '0);
			side_s4.t_zero <= tz;
			side_s4.t_one  <= !tz && (proj_s3[psd_pkg::PROJ_W-2:0] >= len2_s3);
			rem_s4         <= proj_s3[psd_pkg::LEN_W-1:0];
			len2_s4        <= len2_s3;
		end
	end

	assign out_vld = vld_s4;
	assign side    = side_s4;
	assign rem     = rem_s4;
	assign len2    = len2_s4;

endmodule

// ===== rtl/psd_div.sv =====
`timescale 1ns / 1ps

module psd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  psd_pkg::side_t                 in_side,
	input  logic [psd_pkg::LEN_W-1:0]      in_rem,
	input  logic [psd_pkg::LEN_W-1:0]      in_len2,
	output logic                           out_vld,
	output psd_pkg::side_t                 out_side,
	output logic [psd_pkg::T_BITS-1:0]     quo
);

	localparam int N  = psd_pkg::T_BITS;
	localparam int LW = psd_pkg::LEN_W;

	logic                vld_s  [N+1];
	psd_pkg::side_t      side_s [N+1];
	logic [LW-1:0]       rem_s  [N+1];
	logic [LW-1:0]       len2_s [N+1];
	logic [N-1:0]        quo_s  [N+1];

	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;
	assign rem_s[0]  = in_rem;
	assign len2_s[0] = in_len2;
	assign quo_s[0]  = '0;

	// One restoring division step per stage, one quotient bit each.
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [LW:0] sh;
		logic        ge;

		assign sh = {rem_s[k], 1'b0};
		assign ge = (sh >= {1'b0, len2_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				len2_s[k+1] <= len2_s[k];
				rem_s[k+1]  <= ge ? LW'(sh - {1'b0, len2_s[k]}) : LW'(sh);
				quo_s[k+1]  <= {quo_s[k][N-2:0], ge};
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_side = side_s[N];
	assign quo      = quo_s[N];

	// A true division keeps the remainder below the divisor.
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[N] && !side_s[N].degen && !side_s[N].t_zero && !side_s[N].t_one)
		|-> (rem_s[N] < len2_s[N]))
		else $error("division remainder not below divisor");

endmodule

// ===== rtl/psd_err.sv =====
`timescale 1ns / 1ps

module psd_err (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  psd_pkg::side_t              in_side,
	input  logic [psd_pkg::T_BITS-1:0]  quo,
	output logic                        out_vld,
	output logic                        out_degen,
	output logic [psd_pkg::SQ_W-1:0]    sum
);

	localparam int DW  = psd_pkg::DW;
	localparam int TW  = psd_pkg::TW;
	localparam int EW  = psd_pkg::ERR_W;
	localparam int H   = psd_pkg::HALF_W;
	localparam int HW  = psd_pkg::HI_W;
	localparam int QW  = psd_pkg::SQE_W;

	logic [7:1] vld;
	logic [7:1] degen;

	psd_pkg::geo_t          geo_s1;
	logic [TW-1:0]          t_s1;
	logic signed [DW-1:0]   rx_s2, ry_s2;
	logic signed [DW+TW-1:0] tx_s2, ty_s2;
	logic signed [EW-1:0]   ex_s3, ey_s3;
	logic [EW-1:0]          mx_s4, my_s4;
	logic [2*HW-1:0]        hhx_s5, hhy_s5;
	logic [HW+H-1:0]        hlx_s5, hly_s5;
	logic [2*H-1:0]         llx_s5, lly_s5;
	logic [QW-1:0]          sqx_s6, sqy_s6;
	logic [psd_pkg::SQ_W-1:0] sum_s7;

	// Valid and flag bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[6:1], in_vld};
		end
	end

	// Clamp t, form the error vector, then square it in halves.
	always_ff @(posedge clk) begin
		if (en) begin
			degen  <= {degen[6:1], in_side.degen};
			geo_s1 <= in_side.g;
			if (in_side.degen || in_side.t_zero) begin
				t_s1 <= '0;
			end else if (in_side.t_one) begin
				t_s1 <= TW'(1) << psd_pkg::T_BITS;
			end else begin
				t_s1 <= {1'b0, quo};
			end

			rx_s2 <= geo_s1.rx;
			ry_s2 <= geo_s1.ry;
			tx_s2 <= geo_s1.dx * $signed({1'b0, t_s1});
			ty_s2 <= geo_s1.dy * $signed({1'b0, t_s1});

			ex_s3 <= (EW'(rx_s2) <<< psd_pkg::T_BITS) - EW'(tx_s2);
			ey_s3 <= (EW'(ry_s2) <<< psd_pkg::T_BITS) - EW'(ty_s2);

			mx_s4 <= ex_s3[EW-1] ? EW'(-ex_s3) : EW'(ex_s3);
			my_s4 <= ey_s3[EW-1] ? EW'(-ey_s3) : EW'(ey_s3);

			hhx_s5 <= mx_s4[EW-1:H] * mx_s4[EW-1:H];
			hlx_s5 <= mx_s4[EW-1:H] * mx_s4[H-1:0];
			llx_s5 <= mx_s4[H-1:0] * mx_s4[H-1:0];
			hhy_s5 <= my_s4[EW-1:H] * my_s4[EW-1:H];
			hly_s5 <= my_s4[EW-1:H] * my_s4[H-1:0];
			lly_s5 <= my_s4[H-1:0] * my_s4[H-1:0];

			sqx_s6 <= (QW'(hhx_s5) << (2*H)) + (QW'(hlx_s5) << (H+1)) + QW'(llx_s5);
			sqy_s6 <= (QW'(hhy_s5) << (2*H)) + (QW'(hly_s5) << (H+1)) + QW'(lly_s5);

			sum_s7 <= psd_pkg::SQ_W'(sqx_s6) + psd_pkg::SQ_W'(sqy_s6);
		end
	end

	assign out_vld   = vld[7];
	assign out_degen = degen[7];
	assign sum       = sum_s7;

endmodule

// ===== rtl/psd_sqrt.sv =====
`timescale 1ns / 1ps

module psd_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic                        in_degen,
	input  logic [psd_pkg::SQ_W-1:0]    rad,
	output logic                        out_vld,
	output logic                        out_degen,
	output logic [psd_pkg::RT_W-1:0]    root
);

	localparam int N  = psd_pkg::RT_W;
	localparam int SW = psd_pkg::SQ_W;
	localparam int RW = psd_pkg::RW;

	logic            vld_s   [N+1];
	logic            degen_s [N+1];
	logic [SW-1:0]   rad_s   [N+1];
	logic [RW-1:0]   rem_s   [N+1];
	logic [N-1:0]    root_s  [N+1];
	logic [N:0]      vld_vec;

	assign vld_s[0]   = in_vld;
	assign degen_s[0] = in_degen;
	assign rad_s[0]   = rad;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;

	// One root bit per stage, digit by digit from the top bit pair.
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW-1:0] sh;
		logic [RW-1:0] trial;
		logic          ge;

		assign sh    = {rem_s[k][RW-3:0], rad_s[k][SW-1:SW-2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign ge    = (sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				degen_s[k+1] <= degen_s[k];
				rad_s[k+1]   <= {rad_s[k][SW-3:0], 2'b00};
				rem_s[k+1]   <= ge ? (sh - trial) : sh;
				root_s[k+1]  <= {root_s[k][N-2:0], ge};
			end
		end
	end

	for (genvar k = 0; k <= N; k++) begin : g_vec
		assign vld_vec[k] = vld_s[k];
	end

	assign out_vld   = vld_s[N];
	assign out_degen = degen_s[N];
	assign root      = root_s[N];

	// A held pipeline keeps every valid bit in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_vec[N:1]))
		else $error("root pipeline moved while held");

	// The remainder never exceeds twice the partial root.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[N] |-> (rem_s[N] <= {2'b00, root_s[N], 1'b0}))
		else $error("root remainder out of bound");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [psd_pkg::COORD_BITS-1:0] point_x, point_y, start_x, start_y, end_x, end_y;
	logic out_valid;
	logic out_stall;
	logic [psd_pkg::DIST_W-1:0] distance;
	logic degenerate;

	typedef struct {
		logic [psd_pkg::DIST_W-1:0] dist_val;
		logic degen;
	} dist_word_t;

	dist_word_t expected_q[$];
	int fail_count;
	bit idle_enable;

	point_segment_distance_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y),
		.start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance(distance), .degenerate(degenerate)
	);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Integer square root, truncated, of a radicand up to 128 bits.
	function automatic logic [63:0] isqrt(input logic [127:0] rad);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if ({64'd0, trial} * {64'd0, trial} <= rad)
				root = trial;
		end
		return root;
	endfunction

	// Distance from the point to the nearest point of the segment.
	function automatic dist_word_t segment_distance(
		input logic signed [psd_pkg::COORD_BITS-1:0] px, py, sx, sy, ex, ey);
		dist_word_t res;
		longint dx, dy, rx, ry, len2, proj, t, rem, errx, erry;
		logic [127:0] sum;
		logic [63:0] root;
		dx = longint'(ex) - longint'(sx);
		dy = longint'(ey) - longint'(sy);
		rx = longint'(px) - longint'(sx);
		ry = longint'(py) - longint'(sy);
		len2 = dx * dx + dy * dy;
		proj = dx * rx + dy * ry;
		t = 0;
		res.degen = 1'b0;
		if (len2 == 0)
			res.degen = 1'b1;
		else if (proj <= 0)
			t = 0;
		else if (proj >= len2)
			t = longint'(1) << psd_pkg::T_BITS;
		else begin
			rem = proj;
			for (int i = 0; i < psd_pkg::T_BITS; i++) begin
				rem = rem << 1;
				t = t << 1;
				if (rem >= len2) begin
					rem = rem - len2;
					t = t | 1;
				end
			end
		end
		errx = rx * (longint'(1) << psd_pkg::T_BITS) - dx * t;
		erry = ry * (longint'(1) << psd_pkg::T_BITS) - dy * t;
		if (errx < 0) errx = -errx;
		if (erry < 0) erry = -erry;
		sum = 128'(errx) * 128'(errx) + 128'(erry) * 128'(erry);
		root = isqrt(sum);
		res.dist_val = psd_pkg::DIST_W'(root >> (psd_pkg::T_BITS - psd_pkg::FRAC_BITS));
		return res;
	endfunction

	// Send one word and record its expected distance.
	task automatic send_word(input logic signed [psd_pkg::COORD_BITS-1:0] px, py, sx, sy,
		ex, ey);
		int gap;
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px; point_y <= py;
		start_x <= sx; start_y <= sy;
		end_x <= ex; end_y <= ey;
		expected_q.push_back(segment_distance(px, py, sx, sy, ex, ey));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Lower valid once the last word of a phase has gone.
	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [psd_pkg::COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return psd_pkg::COORD_BITS'($urandom_range(0, 64) - 32);
			default: return psd_pkg::COORD_BITS'($urandom);
		endcase
	endfunction

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		dist_word_t exp_word;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word distance=%0d degenerate=%0d",
					$time, distance, degenerate);
				fail_count++;
			end else begin
				exp_word = expected_q.pop_front();
				if (distance !== exp_word.dist_val) begin
					$display("%0t: distance expected %0d actual %0d",
						$time, exp_word.dist_val, distance);
					fail_count++;
				end
				if (degenerate !== exp_word.degen) begin
					$display("%0t: degenerate expected %0d actual %0d",
						$time, exp_word.degen, degenerate);
					fail_count++;
				end
			end
		end
	end

	// Receiver stalls in random bursts while idling is enabled.
	always @(posedge clk) begin
		int burst;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 7) == 0) begin
			burst = $urandom_range(1, 13);
			out_stall <= 1'b1;
			repeat (burst) @(posedge clk);
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic test_extremes();
		logic signed [psd_pkg::COORD_BITS-1:0] mn, mx;
		mn = 16'sh8000;
		mx = 16'sh7fff;
		send_word(mx, mx, mn, mn, mn, mn);
		send_word(mn, mn, mx, mx, mx, mx);
		send_word(mx, mn, mn, mx, mx, mn);
		send_word(mn, mx, mn, mn, mx, mx);
		send_word(mx, mx, mn, mn, mx, mn);
		send_word(mn, mn, mx, mx, mn, mx);
		send_word(16'sd0, 16'sd0, mn, 16'sd0, mx, 16'sd0);
		send_word(-16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		end_burst();
	endtask

	task automatic test_clamp_cases();
		// Projection before start, past end, interior, on the segment, at the endpoints, and degenerate segments.
		send_word(-16'sd10, 16'sd5, 16'sd0, 16'sd0, 16'sd10, 16'sd0);
		send_word(16'sd25, -16'sd7, 16'sd0, 16'sd0, 16'sd10, 16'sd0);
		send_word(16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd10, 16'sd0);
		send_word(16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0);
		send_word(16'sd1, 16'sd2, 16'sd0, 16'sd0, 16'sd3, 16'sd7);
		send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_word(16'sd7, -16'sd3, 16'sd7, -16'sd3, 16'sd9, 16'sd1);
		send_word(16'sd9, 16'sd1, 16'sd7, -16'sd3, 16'sd9, 16'sd1);
		send_word(16'sd100, 16'sd3, -16'sd5, -16'sd5, -16'sd5, -16'sd5);
		send_word(16'sd2, 16'sd9, 16'sd1, 16'sd1, 16'sd1, 16'sd2);
		end_burst();
	endtask

	task automatic wait_drain();
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_random(input int count);
		logic signed [psd_pkg::COORD_BITS-1:0] sx, sy;
		for (int i = 0; i < count; i++) begin
			sx = rand_coord();
			sy = rand_coord();
			if ($urandom_range(0, 15) == 0)
				send_word(rand_coord(), rand_coord(), sx, sy, sx, sy);
			else
				send_word(rand_coord(), rand_coord(), sx, sy, rand_coord(), rand_coord());
		end
		end_burst();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		point_x = '0; point_y = '0;
		start_x = '0; start_y = '0;
		end_x = '0; end_y = '0;
		fail_count = 0;
		idle_enable = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_clamp_cases();
		test_random(600);
		// Hold the sender until the pipeline has emptied.
		wait_drain();
		test_random(500);
		idle_enable = 1'b0;
		test_random(200);
		wait_drain();
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
